// ===== rtl/stps_pkg.sv =====
// ----------------------------------------------------------------------------
// stps_pkg: shared types and constants of the servo test pattern slew block
// Register codes, pattern mode codes, configuration and per-channel records.
// ----------------------------------------------------------------------------
package stps_pkg;

   localparam int CHANNELS = 8;
   localparam int CHAN_W   = 3;
   localparam int VALUE_W  = 12;
   localparam int STEP_W   = 8;
   localparam int MODE_W   = 3;
   localparam int CSR_W    = 12;
   localparam int CSR_IDX_W = 3;
   // working width for value +/- step without overflow
   localparam int CALC_W   = VALUE_W + 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_NEG125 = 3'd0,
      MODE_NEG100 = 3'd1,
      MODE_MID    = 3'd2,
      MODE_OFF    = 3'd3,
      MODE_SWEEP  = 3'd4,
      MODE_POS100 = 3'd5,
      MODE_POS125 = 3'd6,
      MODE_HOLD   = 3'd7
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEST_MODE       = 3'd0,
      CSR_STEP_SIZE       = 3'd1,
      CSR_VALUE_MIN_LIMIT = 3'd2,
      CSR_VALUE_MIN       = 3'd3,
      CSR_VALUE_MID       = 3'd4,
      CSR_VALUE_MAX       = 3'd5,
      CSR_VALUE_MAX_LIMIT = 3'd6
   } csr_index_type;

   localparam logic [STEP_W-1:0]         RST_STEP_SIZE       = 8'd10;
   localparam logic signed [VALUE_W-1:0] RST_VALUE_MIN_LIMIT = -12'sd1250;
   localparam logic signed [VALUE_W-1:0] RST_VALUE_MIN       = -12'sd1000;
   localparam logic signed [VALUE_W-1:0] RST_VALUE_MID       = 12'sd0;
   localparam logic signed [VALUE_W-1:0] RST_VALUE_MAX       = 12'sd1000;
   localparam logic signed [VALUE_W-1:0] RST_VALUE_MAX_LIMIT = 12'sd1250;

   typedef struct packed {
      mode_type                    test_mode;
      logic [STEP_W-1:0]           step_size;
      logic signed [VALUE_W-1:0]   value_min_limit;
      logic signed [VALUE_W-1:0]   value_min;
      logic signed [VALUE_W-1:0]   value_mid;
      logic signed [VALUE_W-1:0]   value_max;
      logic signed [VALUE_W-1:0]   value_max_limit;
   } cfg_type;

   // per-channel state as read out of the channel store
   typedef struct packed {
      logic signed [VALUE_W-1:0] held;
      logic                      down;
      logic                      pending;
   } chan_state_type;

   // write into the channel store; a write clears the capture flag unless an arm comes in the same cycle
   typedef struct packed {
      logic                      en;
      logic [CHAN_W-1:0]         idx;
      logic signed [VALUE_W-1:0] held;
      logic                      down;
   } chan_wr_type;

endpackage

// ===== rtl/stps_chan_regs.sv =====
// ----------------------------------------------------------------------------
// stps_chan_regs: per-channel state store
// Held value, sweep direction and capture flag for each channel.
// ----------------------------------------------------------------------------
module stps_chan_regs (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         arm,
   input  logic [stps_pkg::CHAN_W-1:0]  rd_idx,
   output stps_pkg::chan_state_type     rd_state,
   input  stps_pkg::chan_wr_type        wr
);
   import stps_pkg::*;

   logic signed [VALUE_W-1:0] held_ff [CHANNELS];
   logic signed [VALUE_W-1:0] held_in [CHANNELS];
   logic [CHANNELS-1:0]       down_ff;
   logic [CHANNELS-1:0]       down_in;
   logic [CHANNELS-1:0]       pending_ff;
   logic [CHANNELS-1:0]       pending_in;

   always_comb begin
      held_in    = held_ff;
      down_in    = down_ff;
      pending_in = pending_ff;
      if (wr.en) begin
         held_in[wr.idx]    = wr.held;
         down_in[wr.idx]    = wr.down;
         pending_in[wr.idx] = 1'b0;
      end
      // leaving off arms capture on every channel
      if (arm) begin
         pending_in = '1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            held_ff[i] <= '0;
         end
         down_ff    <= '0;
         pending_ff <= '0;
      end else begin
         held_ff    <= held_in;
         down_ff    <= down_in;
         pending_ff <= pending_in;
      end
   end

   assign rd_state.held    = held_ff[rd_idx];
   assign rd_state.down    = down_ff[rd_idx];
   assign rd_state.pending = pending_ff[rd_idx];

`ifndef SYNTH
   a_arm_sets_all : assert property (@(posedge clock) disable iff (reset)
      arm |=> (&pending_ff))
      else $error("capture flags not all set after arm");

   a_write_clears : assert property (@(posedge clock) disable iff (reset)
      (wr.en && !arm) |=> !pending_ff[$past(wr.idx)])
      else $error("capture flag survived a channel write");
`endif

endmodule

// ===== rtl/stps_calc.sv =====
// ----------------------------------------------------------------------------
// stps_calc: one pattern step
// Slew toward a fixed target with clamping, triangle sweep between bounds, or hold.
// ----------------------------------------------------------------------------
module stps_calc (
   input  stps_pkg::cfg_type                    cfg,
   input  logic signed [stps_pkg::VALUE_W-1:0]  cur_value,
   input  logic                                 cur_down,
   output logic signed [stps_pkg::VALUE_W-1:0]  nxt_value,
   output logic                                 nxt_down
);
   import stps_pkg::*;

   logic signed [CALC_W-1:0] cur_s;
   logic signed [CALC_W-1:0] step_s;
   logic signed [CALC_W-1:0] sum_up;
   logic signed [CALC_W-1:0] sum_dn;
   logic signed [CALC_W-1:0] tgt_s;
   logic signed [CALC_W-1:0] min_s;
   logic signed [CALC_W-1:0] max_s;
   logic signed [CALC_W-1:0] sweep_s;
   logic signed [VALUE_W-1:0] slew_v;

   assign cur_s  = CALC_W'(cur_value);
   assign step_s = signed'(CALC_W'(cfg.step_size));
   assign sum_up = cur_s + step_s;
   assign sum_dn = cur_s - step_s;
   assign min_s  = CALC_W'(cfg.value_min);
   assign max_s  = CALC_W'(cfg.value_max);
   assign sweep_s = cur_down ? sum_dn : sum_up;

   // slew target per mode
   always_comb begin
      case (cfg.test_mode)
         MODE_NEG125: tgt_s = CALC_W'(cfg.value_min_limit);
         MODE_NEG100: tgt_s = CALC_W'(cfg.value_min);
         MODE_MID:    tgt_s = CALC_W'(cfg.value_mid);
         MODE_POS100: tgt_s = CALC_W'(cfg.value_max);
         MODE_POS125: tgt_s = CALC_W'(cfg.value_max_limit);
         default:     tgt_s = cur_s;
      endcase
   end

   always_comb begin
      if (cur_s < tgt_s) begin
         slew_v = (sum_up > tgt_s) ? VALUE_W'(tgt_s) : VALUE_W'(sum_up);
      end else if (cur_s > tgt_s) begin
         slew_v = (sum_dn < tgt_s) ? VALUE_W'(tgt_s) : VALUE_W'(sum_dn);
      end else begin
         slew_v = cur_value;
      end
   end

   always_comb begin
      nxt_value = cur_value;
      nxt_down  = cur_down;
      case (cfg.test_mode)
         MODE_SWEEP: begin
            // overshoot clamps and flips direction; upper bound checked first
            if (sweep_s > max_s) begin
               nxt_value = cfg.value_max;
               nxt_down  = !cur_down;
            end else if (sweep_s < min_s) begin
               nxt_value = cfg.value_min;
               nxt_down  = !cur_down;
            end else begin
               nxt_value = VALUE_W'(sweep_s);
            end
         end
         MODE_HOLD, MODE_OFF: begin
            nxt_value = cur_value;
         end
         default: begin
            nxt_value = slew_v;
         end
      endcase
   end

endmodule

// ===== rtl/servo_test_pattern_slew.sv =====
// ----------------------------------------------------------------------------
// servo_test_pattern_slew: servo exerciser top level
// Per-channel slew / sweep test pattern, one channel tick per request.
// ----------------------------------------------------------------------------
// Each request is one tick for one channel and yields at most one response
// carrying the channel's new output value. The block takes one request per
// cycle unless a held response stalls it: a request register feeds the
// per-channel state lookup and the single add/compare/clamp step, whose
// result is written back into the channel store and loaded into the response
// register at the same edge, so a tick for the same channel in the very next
// cycle already sees the update. Off mode and throttle ticks give no
// response and never wait on the response side. Writing test_mode from off
// to any other code arms a capture on every channel: the next tick of each
// channel first takes its present value and points the sweep upward.
// Configuration writes are expected only while no request is in flight.
// ----------------------------------------------------------------------------
module servo_test_pattern_slew (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [stps_pkg::CHAN_W-1:0]          req_chan_index,
   input  logic signed [stps_pkg::VALUE_W-1:0]  req_present_value,
   input  logic                                 req_is_throttle,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [stps_pkg::CHAN_W-1:0]          rsp_out_channel,
   output logic signed [stps_pkg::VALUE_W-1:0]  rsp_out_value,
   // configuration writes
   input  logic                                 csr_wen,
   input  logic [stps_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [stps_pkg::CSR_W-1:0]           csr_wdata
);
   import stps_pkg::*;

   // configuration registers
   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    arm;

   // request register
   logic                      s1_valid_ff;
   logic                      s1_valid_in;
   logic [CHAN_W-1:0]         s1_chan_ff;
   logic signed [VALUE_W-1:0] s1_present_ff;
   logic                      s1_throttle_ff;

   // response register
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [CHAN_W-1:0]         rsp_chan_ff;
   logic signed [VALUE_W-1:0] rsp_value_ff;

   chan_state_type            st;
   chan_wr_type               wr;
   logic                      s1_active;
   logic                      s1_emits;
   logic                      s1_move;
   logic signed [VALUE_W-1:0] cur_value;
   logic                      cur_down;
   logic signed [VALUE_W-1:0] nxt_value;
   logic                      nxt_down;

   // ---------------------------------------------------------------- CSRs
   always_comb begin
      cfg_in = cfg_ff;
      arm    = 1'b0;
      if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_TEST_MODE: begin
               cfg_in.test_mode = mode_type'(csr_wdata[MODE_W-1:0]);
               arm = (cfg_ff.test_mode == MODE_OFF) &&
                     (mode_type'(csr_wdata[MODE_W-1:0]) != MODE_OFF);
            end
            CSR_STEP_SIZE:       cfg_in.step_size       = csr_wdata[STEP_W-1:0];
            CSR_VALUE_MIN_LIMIT: cfg_in.value_min_limit = signed'(csr_wdata[VALUE_W-1:0]);
            CSR_VALUE_MIN:       cfg_in.value_min       = signed'(csr_wdata[VALUE_W-1:0]);
            CSR_VALUE_MID:       cfg_in.value_mid       = signed'(csr_wdata[VALUE_W-1:0]);
            CSR_VALUE_MAX:       cfg_in.value_max       = signed'(csr_wdata[VALUE_W-1:0]);
            CSR_VALUE_MAX_LIMIT: cfg_in.value_max_limit = signed'(csr_wdata[VALUE_W-1:0]);
            default: ;   // unmapped index: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.test_mode       <= MODE_OFF;
         cfg_ff.step_size       <= RST_STEP_SIZE;
         cfg_ff.value_min_limit <= RST_VALUE_MIN_LIMIT;
         cfg_ff.value_min       <= RST_VALUE_MIN;
         cfg_ff.value_mid       <= RST_VALUE_MID;
         cfg_ff.value_max       <= RST_VALUE_MAX;
         cfg_ff.value_max_limit <= RST_VALUE_MAX_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------------------------------------------------- flow control
   // A tick is live when the mode is not off and the channel exists.
   assign s1_active = s1_valid_ff && (cfg_ff.test_mode != MODE_OFF) &&
                      (32'(s1_chan_ff) < CHANNELS);
   assign s1_emits  = s1_active && !s1_throttle_ff;
   // silent ticks drain regardless of the response side
   assign s1_move   = s1_valid_ff && (!s1_emits || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;

   assign s1_valid_in  = req_valid || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = (s1_move && s1_emits) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_chan_ff     <= req_chan_index;
         s1_present_ff  <= req_present_value;
         s1_throttle_ff <= req_is_throttle;
      end
      if (s1_move && s1_emits) begin
         rsp_chan_ff  <= s1_chan_ff;
         rsp_value_ff <= nxt_value;
      end
   end

   // ----------------------------------------------------- channel datapath
   stps_chan_regs u_chan_regs (
      .clock    (clock),
      .reset    (reset),
      .arm      (arm),
      .rd_idx   (s1_chan_ff),
      .rd_state (st),
      .wr       (wr)
   );

   // pending capture replaces the held value and resets the sweep upward
   assign cur_value = st.pending ? s1_present_ff : st.held;
   assign cur_down  = st.pending ? 1'b0 : st.down;

   stps_calc u_calc (
      .cfg       (cfg_ff),
      .cur_value (cur_value),
      .cur_down  (cur_down),
      .nxt_value (nxt_value),
      .nxt_down  (nxt_down)
   );

   // throttle ticks still commit a capture but skip the pattern step
   always_comb begin
      wr.en   = s1_move && s1_active;
      wr.idx  = s1_chan_ff;
      wr.held = s1_throttle_ff ? cur_value : nxt_value;
      wr.down = s1_throttle_ff ? cur_down : nxt_down;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_chan_ff;
   assign rsp_out_value   = rsp_value_ff;

`ifndef SYNTH
   a_rsp_from_tick : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && s1_emits))
      else $error("response appeared without a live tick");

   a_off_silent : assert property (@(posedge clock) disable iff (reset)
      (s1_move && (cfg_ff.test_mode == MODE_OFF)) |=>
         (!rsp_valid_ff || $past(rsp_valid_ff && !rsp_ready)))
      else $error("off mode produced a response");

   a_no_state_when_off : assert property (@(posedge clock) disable iff (reset)
      (cfg_ff.test_mode == MODE_OFF) |-> !wr.en)
      else $error("channel state written in off mode");
`endif

endmodule
